// ===== hdl/first_fit_heap_allocator_core_defines.svh =====
// Assertion macros shared by the allocator core.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk and quiet during reset
`define FFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and quiet during reset
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ffa_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
package ffa_pkg;

  localparam int HEADER_BYTES_DEF = 16;
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int SIZE_BITS_DEF    = 24;

  localparam logic [31:0] HEAP_BASE_RESET  = 32'd0;
  localparam logic [23:0] HEAP_BYTES_RESET = 24'd1048576;

  // operation codes
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_REINIT = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OOM      = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  // configuration register indexes
  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_BYTES = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [23:0] request_size;
    logic [31:0] release_address;
  } req_item_t;

  typedef struct packed {
    logic [31:0] payload_address;
    logic [1:0]  status;
  } rsp_item_t;

endpackage

// ===== hdl/ffa_cell.sv =====
// One segment cell of the rotating segment table.
module ffa_cell import ffa_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF,
  parameter logic [SIZE_BITS-1:0] INIT_SIZE = '0,
  parameter logic INIT_FREE = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 shift,
  input  logic [SIZE_BITS-1:0] shift_size,
  input  logic                 shift_free,
  input  logic                 load,
  input  logic [SIZE_BITS-1:0] load_size,
  input  logic                 load_free,
  output logic [SIZE_BITS-1:0] size,
  output logic                 free
);

  // hold, take the neighbor's entry, or load a rebuilt value
  always_ff @(posedge clk) begin
    if (rst) begin
      size <= INIT_SIZE;
      free <= INIT_FREE;
    end else if (load) begin
      size <= load_size;
      free <= load_free;
    end else if (shift) begin
      size <= shift_size;
      free <= shift_free;
    end
  end

endmodule

// ===== hdl/first_fit_heap_allocator_core.sv =====
// A successful allocate or free of a nonzero address runs a search lap and a rewrite lap of
// the cell ring before the result beat; an allocate with no fit or a free of an unknown
// address runs only the search lap; reinitialize, free of 0 and unused codes go straight
// to the result beat. One item at a time.
// Reset (rst, synchronous) rebuilds the table as one free segment from the reset value
// of heap_bytes and clears the handshake state.
module first_fit_heap_allocator_core import ffa_pkg::*; #(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int SIZE_BITS    = SIZE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req_item,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp_item,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [31:0] cfg_data
);

`include "first_fit_heap_allocator_core_defines.svh"

  localparam int KW = $clog2(MAX_SEGMENTS + 1);
  localparam int TAP2 = 2 % MAX_SEGMENTS;
  localparam logic [33:0] SIZE_MAX34 = (34'd1 << SIZE_BITS) - 34'd1;
  localparam logic [33:0] HDR34 = 34'(HEADER_BYTES);
  localparam logic [33:0] INIT34 =
    (34'(HEAP_BYTES_RESET) > HDR34) ? 34'(HEAP_BYTES_RESET) - HDR34 : 34'd0;
  localparam logic [SIZE_BITS-1:0] INIT_SIZE =
    SIZE_BITS'((INIT34 > SIZE_MAX34) ? SIZE_MAX34 : INIT34);
  localparam logic [KW-1:0] LAST = KW'(MAX_SEGMENTS - 1);
  localparam logic [KW-1:0] NSEG = KW'(MAX_SEGMENTS);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SEARCH  = 6'b000010,
    S_MERGE_A = 6'b000100,
    S_MERGE_B = 6'b001000,
    S_MODIFY  = 6'b010000,
    S_FINISH  = 6'b100000
  } state_t;

  state_t state;

  // configuration
  logic [31:0] heap_base;
  logic [23:0] heap_bytes;

  // item and sequencer registers
  logic [1:0]  op;
  logic [23:0] req_size;
  logic [31:0] rel_addr;
  logic [KW-1:0] step, idx, count;
  logic [31:0] acc, hit_addr;
  logic hit;
  logic [SIZE_BITS-1:0] prev_size, s_prev, s_cur, s_next, rem, m1, m2;
  logic prev_free, f_prev, f_next, split;
  logic [31:0] res_addr;
  logic [1:0]  res_status;

  // cell ring
  logic [SIZE_BITS-1:0] c_size [MAX_SEGMENTS];
  logic                 c_free [MAX_SEGMENTS];
  logic                 shift, load;
  logic [SIZE_BITS-1:0] tail_size, load_size0;
  logic                 tail_free;

  genvar g;
  generate
    for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
      logic [SIZE_BITS-1:0] in_size;
      logic                 in_free;
      if (g == MAX_SEGMENTS - 1) begin : g_tail
        assign in_size = tail_size;
        assign in_free = tail_free;
      end else begin : g_link
        assign in_size = c_size[g+1];
        assign in_free = c_free[g+1];
      end
      ffa_cell #(
        .SIZE_BITS (SIZE_BITS),
        .INIT_SIZE ((g == 0) ? INIT_SIZE : '0),
        .INIT_FREE (g == 0)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift      (shift),
        .shift_size (in_size),
        .shift_free (in_free),
        .load       (load),
        .load_size  ((g == 0) ? load_size0 : '0),
        .load_free  (g == 0),
        .size       (c_size[g]),
        .free       (c_free[g])
      );
    end
  endgenerate

  // window onto the ring head; entries past the table end read as empty
  logic [SIZE_BITS-1:0] w1_size, w2_size;
  logic w1_free, w2_free;
  logic ok1, ok2;
  assign ok1 = (step != LAST);
  assign ok2 = ({1'b0, step} + (KW+1)'(2)) < (KW+1)'(MAX_SEGMENTS);
  assign w1_size = ok1 ? c_size[1 % MAX_SEGMENTS] : '0;
  assign w1_free = ok1 ? c_free[1 % MAX_SEGMENTS] : 1'b0;
  assign w2_size = ok2 ? c_size[TAP2] : '0;
  assign w2_free = ok2 ? c_free[TAP2] : 1'b0;

  // rebuilt entry zero from heap_bytes
  logic [33:0] rb34;
  always_comb begin
    rb34 = (34'(heap_bytes) > HDR34) ? 34'(heap_bytes) - HDR34 : 34'd0;
    load_size0 = SIZE_BITS'((rb34 > SIZE_MAX34) ? SIZE_MAX34 : rb34);
  end

  // search match at the ring head
  logic in_table, fit, match;
  assign in_table = step < count;
  assign fit = c_free[0] && (34'(c_size[0]) >= 34'(req_size));
  assign match = in_table && !hit && ((op == OP_ALLOC) ? fit : (acc == rel_addr));

  // merge sums
  logic [33:0] sum_a, sum_b, split_lim;
  assign sum_a = 34'(s_cur) + 34'(s_next) + HDR34;
  assign sum_b = 34'(s_prev) + 34'(m1) + HDR34;
  assign split_lim = 34'(req_size) + HDR34 + 34'd1;

  // rewrite data for the ring tail
  logic [KW-1:0] e_idx;
  logic [1:0] del;
  assign e_idx = f_prev ? idx - KW'(1) : idx;
  assign del = 2'(f_prev) + 2'(f_next);

  always_comb begin
    tail_size = c_size[0];
    tail_free = c_free[0];
    if (state == S_MODIFY) begin
      if (op == OP_ALLOC) begin
        if (step == idx) begin
          tail_size = split ? SIZE_BITS'(req_size) : c_size[0];
          tail_free = 1'b0;
        end else if (split && step == idx + KW'(1)) begin
          tail_size = rem;
          tail_free = 1'b1;
        end else if (split && step > idx) begin
          tail_size = prev_size;
          tail_free = prev_free;
        end
      end else begin
        if (step == e_idx) begin
          tail_size = f_prev ? m2 : m1;
          tail_free = 1'b1;
        end else if (step > e_idx) begin
          case (del)
            2'd1: begin
              tail_size = w1_size;
              tail_free = w1_free;
            end
            2'd2: begin
              tail_size = w2_size;
              tail_free = w2_free;
            end
            default: begin
              tail_size = c_size[0];
              tail_free = c_free[0];
            end
          endcase
        end
      end
    end
  end

  assign req_stall = rst || (state != S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= HEAP_BASE_RESET;
      heap_bytes <= HEAP_BYTES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEAP_BASE:  heap_base  <= cfg_data;
        REG_HEAP_BYTES: heap_bytes <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    shift = (state == S_SEARCH) || (state == S_MODIFY);
    load  = (state == S_IDLE) && req_valid && (req_item.operation == OP_REINIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= KW'(1);
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_FINISH) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op         <= req_item.operation;
            req_size   <= req_item.request_size;
            rel_addr   <= req_item.release_address;
            step       <= '0;
            acc        <= heap_base + 32'(HEADER_BYTES);
            hit        <= 1'b0;
            prev_size  <= '0;
            prev_free  <= 1'b0;
            res_addr   <= '0;
            res_status <= ST_OK;
            if (req_item.operation == OP_REINIT) count <= KW'(1);
            if (req_item.operation == OP_ALLOC ||
                (req_item.operation == OP_FREE && req_item.release_address != '0)) begin
              state <= S_SEARCH;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_SEARCH: begin
          if (match) begin
            hit      <= 1'b1;
            idx      <= step;
            hit_addr <= acc;
            s_prev   <= prev_size;
            f_prev   <= prev_free;
            s_cur    <= c_size[0];
            s_next   <= w1_size;
            f_next   <= w1_free;
          end
          acc       <= acc + 32'(c_size[0]) + 32'(HEADER_BYTES);
          prev_size <= c_size[0];
          prev_free <= c_free[0];
          step      <= step + KW'(1);
          if (step == LAST) begin
            if (hit || match) begin
              state <= S_MERGE_A;
            end else begin
              res_status <= (op == OP_ALLOC) ? ST_OOM : ST_NOTFOUND;
              state      <= S_FINISH;
            end
          end
        end
        S_MERGE_A: begin
          split <= (34'(s_cur) > split_lim) && (count < NSEG);
          rem   <= SIZE_BITS'(34'(s_cur) - 34'(req_size) - HDR34);
          if (op == OP_ALLOC) begin
            m1 <= s_cur;
          end else if (f_next) begin
            m1 <= SIZE_BITS'((sum_a > SIZE_MAX34) ? SIZE_MAX34 : sum_a);
          end else begin
            m1 <= s_cur;
          end
          state <= S_MERGE_B;
        end
        S_MERGE_B: begin
          m2        <= SIZE_BITS'((sum_b > SIZE_MAX34) ? SIZE_MAX34 : sum_b);
          step      <= '0;
          prev_size <= '0;
          prev_free <= 1'b0;
          state     <= S_MODIFY;
        end
        S_MODIFY: begin
          prev_size <= c_size[0];
          prev_free <= c_free[0];
          step      <= step + KW'(1);
          if (step == LAST) begin
            if (op == OP_ALLOC) begin
              res_addr <= hit_addr;
              if (split) count <= count + KW'(1);
            end else begin
              count <= count - KW'(del);
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid                <= 1'b1;
            rsp_item.payload_address <= res_addr;
            rsp_item.status          <= res_status;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `FFA_ASSERT_NOW(a_count_range, 1'b1, (count >= KW'(1)) && (count <= NSEG), "segment count out of range")
  `FFA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "took a beat while busy")
  `FFA_ASSERT_NEXT(a_reinit_count, req_valid && !req_stall && req_item.operation == OP_REINIT, count == KW'(1), "reinit left count")
  `FFA_ASSERT_NEXT(a_modify_done, state == S_MODIFY && step == LAST, state == S_FINISH, "rewrite lap overran")

endmodule

// ===== tb/sv/tb_first_fit_heap_allocator_core.sv =====
// Testbench for the first-fit heap allocator core: directed and random traffic with a table model.
`timescale 1ns / 100ps
module tb_first_fit_heap_allocator_core;
  import ffa_pkg::*;

  localparam int HDR  = HEADER_BYTES_DEF;
  localparam int NSEG = MAX_SEGMENTS_DEF;
  localparam logic [23:0] SZ_MAX = 24'hFFFFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_item_t   req_item = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_item_t   rsp_item;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  first_fit_heap_allocator_core dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // heap table model
  logic [31:0] mdl_base;
  logic [23:0] mdl_bytes;
  logic [23:0] seg_size [NSEG];
  logic        seg_free [NSEG];
  int          seg_cnt;

  rsp_item_t   rsp_pending [$];
  logic [31:0] live_addrs [$];
  int          mismatches = 0;
  int          long_hold = 0;
  bit          rsp_random = 1'b1;

  function automatic logic [23:0] clip_size(logic [63:0] v);
    return (v > {40'd0, SZ_MAX}) ? SZ_MAX : v[23:0];
  endfunction

  function automatic void table_rebuild();
    for (int k = 0; k < NSEG; k++) begin
      seg_size[k] = '0;
      seg_free[k] = 1'b0;
    end
    seg_size[0] = clip_size((mdl_bytes > HDR) ? 64'(mdl_bytes) - HDR : 64'd0);
    seg_free[0] = 1'b1;
    seg_cnt = 1;
  endfunction

  function automatic void table_remove(int idx);
    for (int k = idx; k + 1 < seg_cnt; k++) begin
      seg_size[k] = seg_size[k+1];
      seg_free[k] = seg_free[k+1];
    end
    seg_size[seg_cnt-1] = '0;
    seg_free[seg_cnt-1] = 1'b0;
    seg_cnt--;
  endfunction

  function automatic rsp_item_t heap_predict(req_item_t it);
    rsp_item_t   r;
    logic [31:0] a;
    logic [63:0] sz, rq;
    int          i;
    r = '0;
    r.status = ST_OK;
    a = mdl_base + HDR;
    if (it.operation == OP_ALLOC) begin
      rq = 64'(it.request_size);
      r.status = ST_OOM;
      for (i = 0; i < seg_cnt; i++) begin
        sz = 64'(seg_size[i]);
        if (seg_free[i] && sz >= rq) begin
          if (sz > rq + HDR + 1 && seg_cnt < NSEG) begin
            for (int k = seg_cnt; k > i + 1; k--) begin
              seg_size[k] = seg_size[k-1];
              seg_free[k] = seg_free[k-1];
            end
            seg_size[i+1] = 24'(sz - rq - HDR);
            seg_free[i+1] = 1'b1;
            seg_size[i] = rq[23:0];
            seg_cnt++;
          end
          seg_free[i] = 1'b0;
          r.status = ST_OK;
          r.payload_address = a;
          break;
        end
        a = a + HDR + 32'(seg_size[i]);
      end
    end else if (it.operation == OP_FREE) begin
      if (it.release_address != 0) begin
        for (i = 0; i < seg_cnt; i++) begin
          if (a == it.release_address) break;
          a = a + 32'(seg_size[i]) + HDR;
        end
        if (i >= seg_cnt) r.status = ST_NOTFOUND;
        else begin
          seg_free[i] = 1'b1;
          if (i + 1 < seg_cnt && seg_free[i+1]) begin
            seg_size[i] = clip_size(64'(seg_size[i]) + seg_size[i+1] + HDR);
            table_remove(i + 1);
          end
          if (i > 0 && seg_free[i-1]) begin
            seg_size[i-1] = clip_size(64'(seg_size[i-1]) + seg_size[i] + HDR);
            table_remove(i);
          end
        end
      end
    end else if (it.operation == OP_REINIT) begin
      table_rebuild();
    end
    return r;
  endfunction

  // one request beat, after a gap with req_valid low, lengthened at random when gap is set
  task automatic send_req(logic [1:0] op, logic [23:0] sz, logic [31:0] ra, bit gap = 1'b1);
    req_item_t it;
    rsp_item_t r;
    int        w;
    it.operation = op;
    it.request_size = sz;
    it.release_address = ra;
    w = gap ? $urandom_range(0, 3) : 0;
    repeat (w + 1) @(negedge clk);
    req_valid <= 1'b1;
    req_item <= it;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    r = heap_predict(it);
    rsp_pending.push_back(r);
    if (op == OP_ALLOC && r.status == ST_OK && r.payload_address != 0)
      live_addrs.push_back(r.payload_address);
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (rsp_pending.size() != 0) @(negedge clk);
    repeat (2 * NSEG + 10) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HEAP_BASE) mdl_base = v;
    else mdl_bytes = v[23:0];
  endtask

  function automatic logic [31:0] pick_free_addr();
    int n;
    logic [31:0] a;
    if (live_addrs.size() == 0 || $urandom_range(0, 9) == 0) return $urandom();
    n = $urandom_range(0, live_addrs.size() - 1);
    a = live_addrs[n];
    live_addrs.delete(n);
    return a;
  endfunction

  // response stall: random each cycle, a long counted hold-off, or off when rsp_random is clear
  always @(negedge clk) begin
    if (long_hold > 0) begin
      rsp_stall <= 1'b1;
      long_hold <= long_hold - 1;
    end else if (rsp_random) rsp_stall <= ($urandom_range(0, 3) != 0) && ($urandom_range(0, 1) == 0);
    else rsp_stall <= 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    rsp_item_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat addr=%h st=%0d",
                                       rsp_item.payload_address, rsp_item.status);
      end else begin
        e = rsp_pending.pop_front();
        if (e.payload_address !== rsp_item.payload_address || e.status !== rsp_item.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp addr=%h st=%0d got addr=%h st=%0d",
                     e.payload_address, e.status, rsp_item.payload_address, rsp_item.status);
        end
      end
    end
  end

  task automatic test_directed();
    send_req(OP_ALLOC, 24'd0, 0);
    send_req(OP_ALLOC, 24'd100, 0);
    send_req(OP_ALLOC, SZ_MAX, 0);
    send_req(OP_FREE, 0, 32'd0);
    send_req(OP_FREE, 0, 32'hFFFFFFFF);
    send_req(OP_FREE, 0, 32'd16);
    send_req(OP_FREE, 0, 32'd16);
    send_req(2'd3, SZ_MAX, 32'hFFFFFFFF);
    send_req(OP_ALLOC, 24'd1048560, 0);
    send_req(OP_ALLOC, 24'd1, 0);
    send_req(OP_REINIT, 0, 0);
    send_req(OP_ALLOC, 24'd1048543, 0);
    send_req(OP_ALLOC, 24'd0, 0);
    send_req(OP_REINIT, 0, 0);
    live_addrs.delete();
    wait_drain();
  endtask

  task automatic test_config_extremes();
    write_cfg(REG_HEAP_BYTES, 32'd0);
    send_req(OP_REINIT, 0, 0);
    send_req(OP_ALLOC, 24'd0, 0);
    send_req(OP_ALLOC, 24'd1, 0);
    wait_drain();
    write_cfg(REG_HEAP_BASE, 32'hFFFFFFF0);
    write_cfg(REG_HEAP_BYTES, 32'hFFFFFFFF);
    send_req(OP_REINIT, 0, 0);
    send_req(OP_ALLOC, 24'd5, 0);
    send_req(OP_ALLOC, 24'd7, 0);
    send_req(OP_FREE, 0, 32'd0);
    send_req(OP_FREE, 0, 32'd21);
    send_req(OP_FREE, 0, 32'd0);
    live_addrs.delete();
    wait_drain();
  endtask

  // fill the table past its depth with tiny allocations, then free mostly live addresses
  task automatic test_table_full();
    write_cfg(REG_HEAP_BASE, 32'h1000);
    write_cfg(REG_HEAP_BYTES, 32'd4096);
    send_req(OP_REINIT, 0, 0);
    live_addrs.delete();
    for (int k = 0; k < NSEG + 4; k++) send_req(OP_ALLOC, 24'($urandom_range(0, 8)), 0);
    for (int k = 0; k < 30; k++) send_req(OP_FREE, 0, pick_free_addr());
    wait_drain();
  endtask

  task automatic test_backpressure();
    long_hold = 2 * NSEG * 8;
    for (int k = 0; k < 6; k++) send_req(OP_ALLOC, 24'($urandom_range(0, 64)), 0, 1'b0);
    wait_drain();
  endtask

  task automatic test_random(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 19);
      if (r < 9) begin
        if ($urandom_range(0, 9) == 0) send_req(OP_ALLOC, 24'($urandom()), $urandom());
        else send_req(OP_ALLOC, 24'($urandom_range(0, 300)), $urandom());
      end else if (r < 18) send_req(OP_FREE, 24'($urandom()), pick_free_addr());
      else if (r == 18) begin
        send_req(OP_REINIT, 24'($urandom()), $urandom());
        live_addrs.delete();
      end else send_req(2'd3, 24'($urandom()), $urandom());
      if (k % 100 == 50) wait_drain();
    end
    wait_drain();
  endtask

  initial begin
    mdl_base = HEAP_BASE_RESET;
    mdl_bytes = HEAP_BYTES_RESET;
    table_rebuild();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_extremes();
    test_table_full();
    test_backpressure();
    write_cfg(REG_HEAP_BASE, 32'h8000_0000);
    write_cfg(REG_HEAP_BYTES, 32'd20000);
    send_req(OP_REINIT, 0, 0);
    live_addrs.delete();
    test_random(250);
    rsp_random = 1'b0;
    write_cfg(REG_HEAP_BASE, $urandom());
    write_cfg(REG_HEAP_BYTES, $urandom_range(0, 3000));
    send_req(OP_REINIT, 0, 0);
    live_addrs.delete();
    test_random(80);
    rsp_random = 1'b1;
    write_cfg(REG_HEAP_BASE, 32'd0);
    write_cfg(REG_HEAP_BYTES, 32'd1048576);
    send_req(OP_REINIT, 0, 0);
    live_addrs.delete();
    test_random(120);
    wait_drain();
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ffa_pkg.sv
hdl/ffa_cell.sv
hdl/first_fit_heap_allocator_core.sv
tb/sv/tb_first_fit_heap_allocator_core.sv
